// ----- rtl/fxalu_pkg.sv -----
// Shared types, constants and operation codes of the Q24.8 fixed-point ALU.
package fxalu_pkg;
    localparam int FRAC_BITS  = 8;
    localparam int DATA_WIDTH = 32;
    localparam int MAG_W      = DATA_WIDTH;
    localparam int NUM_W      = MAG_W + FRAC_BITS + 1;
    localparam int QUO_W      = NUM_W;
    localparam int STAGES     = QUO_W;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
        OP_FROM_INT = 3'd4, OP_TO_INT = 3'd5, OP_INC = 3'd6, OP_DEC = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_DIV_ZERO = 2'd1, ST_SAT = 2'd2, ST_RSVD = 2'd3
    } t_status;

    typedef struct packed {
        logic                          valid;
        t_op                           op;
        logic                          neg;
        logic                          lt;
        logic                          eq;
        logic                          gt;
        logic                          dz;
        logic signed [DATA_WIDTH-1:0]  simple;
        logic [2*MAG_W-1:0]            prod;
    } t_side;

    typedef struct packed {
        logic [NUM_W:0]   rem;
        logic [NUM_W-1:0] num;
        logic [MAG_W:0]   div2;
        logic [QUO_W-1:0] quo;
    } t_dstate;
endpackage

// ----- rtl/fxalu_cell.sv -----
// One restoring-division cell: retires one quotient bit and passes the rest on.
module fxalu_cell import fxalu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_side   i_side,
    input  t_dstate i_d,
    output t_side   o_side,
    output t_dstate o_d
);
    t_side   r_side;
    t_dstate r_d;
    t_dstate n_d;
    logic [NUM_W:0] w_trial;
    logic [NUM_W:0] w_dext;

    always_comb begin
        w_trial = {i_d.rem[NUM_W-1:0], i_d.num[NUM_W-1]};
        w_dext  = {{(NUM_W-MAG_W){1'b0}}, i_d.div2};
        n_d      = i_d;
        n_d.num  = {i_d.num[NUM_W-2:0], 1'b0};
        if (w_trial >= w_dext) begin
            n_d.rem = w_trial - w_dext;
            n_d.quo = {i_d.quo[QUO_W-2:0], 1'b1};
        end else begin
            n_d.rem = w_trial;
            n_d.quo = {i_d.quo[QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side.valid <= i_side.valid;
        end
        if (i_en) begin
            r_side.op     <= i_side.op;
            r_side.neg    <= i_side.neg;
            r_side.lt     <= i_side.lt;
            r_side.eq     <= i_side.eq;
            r_side.gt     <= i_side.gt;
            r_side.dz     <= i_side.dz;
            r_side.simple <= i_side.simple;
            r_side.prod   <= i_side.prod;
            r_d           <= n_d;
        end
    end

    assign o_side = r_side;
    assign o_d    = r_d;
endmodule

// ----- rtl/q24_8_fixed_point_alu.sv -----
// Top level of the Q24.8 fixed-point ALU: input stage, division cell chain, output stage.
// Pipeline: one input register, 41 division cells and one output register lie between input
// accept and result valid; every operation takes the same path.
// Throughput: one item per cycle; the whole chain advances when the output is free.
// The multiplier is registered in the input stage, the divider is one cell per quotient bit.
// Reset (synchronous, active low) clears all valid bits; payload registers are not reset.
module q24_8_fixed_point_alu import fxalu_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_operation,
    input  logic signed [DATA_WIDTH-1:0] i_operand_a,
    input  logic signed [DATA_WIDTH-1:0] i_operand_b,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_result_value,
    output logic                         o_a_less,
    output logic                         o_a_equal,
    output logic                         o_a_greater,
    output logic [1:0]                   o_status
);
    logic w_en;
    logic [MAG_W-1:0] w_ma, w_mb;
    logic signed [DATA_WIDTH-1:0] w_simple;
    logic [MAG_W-1:0] w_tq;
    t_side   r_side;
    t_dstate r_d;
    t_side   w_side [0:STAGES];
    t_dstate w_d    [0:STAGES];

    logic                         r_ovalid;
    logic signed [DATA_WIDTH-1:0] r_res;
    logic                         r_lt, r_eq, r_gt;
    t_status                      r_st;
    t_side                        w_ls;
    logic [2*MAG_W-1:0]           w_mq;
    logic [QUO_W-1:0]             w_q;
    logic                         w_qneg;
    logic [2*MAG_W-1:0]           w_mag;
    logic [2*MAG_W-1:0]           w_lim;
    logic                         w_sat;
    logic [DATA_WIDTH-1:0]        w_limv;
    logic [DATA_WIDTH-1:0]        w_sm;
    t_status                      w_st;
    logic signed [DATA_WIDTH-1:0] w_res;

    assign w_en    = !r_ovalid || i_ready;
    assign o_ready = w_en;

    assign w_ma = i_operand_a[DATA_WIDTH-1] ? MAG_W'(-i_operand_a) : MAG_W'(i_operand_a);
    assign w_mb = i_operand_b[DATA_WIDTH-1] ? MAG_W'(-i_operand_b) : MAG_W'(i_operand_b);
    assign w_tq = w_ma >> FRAC_BITS;

    always_comb begin
        case (t_op'(i_operation))
            OP_ADD:      w_simple = i_operand_a + i_operand_b;
            OP_SUB:      w_simple = i_operand_a - i_operand_b;
            OP_FROM_INT: w_simple = i_operand_a <<< FRAC_BITS;
            OP_TO_INT:   w_simple = i_operand_a[DATA_WIDTH-1] ?
                                    DATA_WIDTH'(-w_tq) : DATA_WIDTH'(w_tq);
            OP_INC:      w_simple = i_operand_a + DATA_WIDTH'(1);
            OP_DEC:      w_simple = i_operand_a - DATA_WIDTH'(1);
            default:     w_simple = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (w_en) begin
            r_side.valid <= i_valid;
        end
        if (w_en) begin
            r_side.op     <= t_op'(i_operation);
            r_side.neg    <= i_operand_a[DATA_WIDTH-1] ^ i_operand_b[DATA_WIDTH-1];
            r_side.lt     <= i_operand_a < i_operand_b;
            r_side.eq     <= i_operand_a == i_operand_b;
            r_side.gt     <= i_operand_a > i_operand_b;
            r_side.dz     <= w_mb == '0;
            r_side.simple <= w_simple;
            r_side.prod   <= w_ma * w_mb;
            r_d.rem  <= '0;
            r_d.num  <= {w_ma, {FRAC_BITS{1'b0}}, 1'b0};
            r_d.div2 <= {1'b0, w_mb};
            r_d.quo  <= '0;
        end
    end

    assign w_side[0] = r_side;
    assign w_d[0]    = r_d;

    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        fxalu_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_side (w_side[g]),
            .i_d    (w_d[g]),
            .o_side (w_side[g+1]),
            .o_d    (w_d[g+1])
        );
    end

    assign w_ls = w_side[STAGES];
    assign w_q  = w_d[STAGES].quo;
    assign w_mq = (w_ls.prod + (2*MAG_W)'(1 << (FRAC_BITS-1))) >> FRAC_BITS;

    always_comb begin
        w_mag = (w_ls.op == OP_MUL) ? w_mq
                                    : (((2*MAG_W)'(w_q) + (2*MAG_W)'(1)) >> 1);
        w_qneg = w_ls.neg && (w_mag != '0);
        w_lim = w_qneg ? ((2*MAG_W)'(1) << (DATA_WIDTH-1))
                       : (((2*MAG_W)'(1) << (DATA_WIDTH-1)) - (2*MAG_W)'(1));
        w_sat  = w_mag > w_lim;
        w_limv = w_lim[DATA_WIDTH-1:0];
        w_sm   = w_sat ? w_limv : w_mag[DATA_WIDTH-1:0];
        w_st   = ST_OK;
        w_res  = w_ls.simple;
        if (w_ls.op == OP_MUL || w_ls.op == OP_DIV) begin
            w_res = w_qneg ? -$signed(w_sm) : $signed(w_sm);
            w_st  = w_sat ? ST_SAT : ST_OK;
            if (w_ls.op == OP_DIV && w_ls.dz) begin
                w_res = '0;
                w_st  = ST_DIV_ZERO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_ovalid <= w_ls.valid;
        end
        if (w_en) begin
            r_res <= w_res;
            r_lt  <= w_ls.lt;
            r_eq  <= w_ls.eq;
            r_gt  <= w_ls.gt;
            r_st  <= w_st;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_result_value = r_res;
    assign o_a_less       = r_lt;
    assign o_a_equal      = r_eq;
    assign o_a_greater    = r_gt;
    assign o_status       = r_st;

    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_a_less, o_a_equal, o_a_greater}))
        else $error("comparison flags not one-hot");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_value) && $stable(o_status))
        else $error("stalled result changed");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DIV_ZERO |-> o_result_value == '0)
        else $error("divide by zero gave nonzero result");
endmodule
